// ===== sv/a85_pkg.sv =====
package a85_pkg;

    localparam int unsigned DigitLow  = 33;
    localparam int unsigned DigitHigh = 117;
    localparam int unsigned Base      = 85;
    localparam int unsigned ZeroChar  = 122;

    // Group held between digits: at most four digits, below 85^4 < 2^26
    localparam int unsigned GroupW = 26;
    // Full group: five digits, below 85^5 < 2^33
    localparam int unsigned FullW  = 33;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_Z_IN_GROUP = 2'd1,
        ST_BAD_CHAR   = 2'd2,
        ST_OVERFLOW   = 2'd3
    } t_status;

    typedef struct packed {
        logic        emit;
        logic [31:0] data;
        logic [2:0]  count;
        t_status     status;
    } t_result;

endpackage

// ===== sv/ascii85_stream_decoder.sv =====
// ASCII85 stream decoder.
// Input channel: one item per character (i_in_char) or an end-of-stream
// marker (i_end_of_stream); whitespace is skipped. Output channel: one
// decoded byte per item with o_status and o_run_last, which flags the last
// byte caused by one input item. An error gives a single zero byte with a
// nonzero status, after which every input item is taken and dropped.
// The first byte of an input item shows in the cycle after it is
// accepted. Items that produce no bytes are taken every cycle. An item that
// produces bytes needs the output register free, or its last byte leaving
// in the same cycle. A four-byte group holds that register until its last
// byte leaves, so a dense run of 'z' gives one byte per cycle while
// i_out_stall is low, with o_in_stall raised while each later 'z' waits.
// Full groups (five characters, four bytes) flow with no input stall.
// Reset (i_rst_n low, synchronous) clears the group, the digit count, the
// error halt and any pending bytes. While i_out_stall is high the current
// byte holds, and an input item that produces bytes waits until the output
// register is free.
module ascii85_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_char,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_run_last
);
    import a85_pkg::*;

    logic [GroupW-1:0] r_group, n_group;
    logic [2:0]        r_count, n_count;
    logic              r_halted, n_halted;
    logic              r_busy, n_busy;
    logic [31:0]       r_data, n_data;
    logic [2:0]        r_left, n_left;
    t_status           r_status, n_status;
    t_result           res;
    logic              in_take;
    logic              out_take;
    logic              out_free;

    a85_decode u_decode (
        .i_halted        (r_halted),
        .i_group         (r_group),
        .i_count         (r_count),
        .i_in_char       (i_in_char),
        .i_end_of_stream (i_end_of_stream),
        .o_group         (n_group),
        .o_count         (n_count),
        .o_halted        (n_halted),
        .o_result        (res)
    );

    assign out_take = r_busy && !i_out_stall;
    assign out_free = !r_busy || (out_take && r_left == 3'd1);
    // hold input only when its bytes would find the output register full
    assign o_in_stall = !out_free && res.emit;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_busy   = r_busy;
        n_data   = r_data;
        n_left   = r_left;
        n_status = r_status;
        if (out_take) begin
            n_left = r_left - 3'd1;
            n_data = {r_data[23:0], 8'd0};
            if (r_left == 3'd1) begin
                n_busy = 1'b0;
            end
        end
        // a new item's bytes replace the last byte leaving this cycle
        if (in_take && res.emit) begin
            n_busy   = 1'b1;
            n_data   = res.data;
            n_left   = res.count;
            n_status = res.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group  <= '0;
            r_count  <= '0;
            r_halted <= 1'b0;
            r_busy   <= 1'b0;
            r_data   <= '0;
            r_left   <= '0;
            r_status <= ST_OK;
        end else begin
            if (in_take) begin
                r_group  <= n_group;
                r_count  <= n_count;
                r_halted <= n_halted;
            end
            r_busy   <= n_busy;
            r_data   <= n_data;
            r_left   <= n_left;
            r_status <= n_status;
        end
    end

    assign o_out_valid = r_busy;
    assign o_out_byte  = r_data[31:24];
    assign o_status    = r_status;
    assign o_run_last  = (r_left == 3'd1);

endmodule

// ===== sv/a85_decode.sv =====
module a85_decode (
    input  logic                        i_halted,
    input  logic [a85_pkg::GroupW-1:0]  i_group,
    input  logic [2:0]                  i_count,
    input  logic [7:0]                  i_in_char,
    input  logic                        i_end_of_stream,
    output logic [a85_pkg::GroupW-1:0]  o_group,
    output logic [2:0]                  o_count,
    output logic                        o_halted,
    output a85_pkg::t_result            o_result
);
    import a85_pkg::*;

    logic              is_blank;
    logic              in_range;
    logic [6:0]        digit;
    logic [FullW-1:0]  acc;
    logic [GroupW:0]   v_inc;
    logic [GroupW-1:0] pad_pow;
    logic [52:0]       prod;
    logic [FullW-1:0]  padded;

    assign is_blank = (i_in_char == 8'd32) || (i_in_char >= 8'd9 && i_in_char <= 8'd13);
    assign in_range = (i_in_char >= 8'(DigitLow)) && (i_in_char <= 8'(DigitHigh));
    assign digit    = 7'(i_in_char - 8'(DigitLow));
    assign acc      = FullW'(i_group) * FullW'(Base) + FullW'(digit);

    // Padding with 'u' digits: v*85^k + (85^k - 1) = (v+1)*85^k - 1
    always_comb begin
        unique case (i_count)
            3'd1:    pad_pow = GroupW'(52200625);
            3'd2:    pad_pow = GroupW'(614125);
            3'd3:    pad_pow = GroupW'(7225);
            default: pad_pow = GroupW'(Base);
        endcase
    end

    assign v_inc  = {1'b0, i_group} + (GroupW+1)'(1);
    assign prod   = 53'(v_inc) * 53'(pad_pow);
    assign padded = prod[FullW-1:0] - FullW'(1);

    always_comb begin
        o_group         = i_group;
        o_count         = i_count;
        o_halted        = i_halted;
        o_result.emit   = 1'b0;
        o_result.data   = '0;
        o_result.count  = 3'd1;
        o_result.status = ST_OK;

        priority if (i_halted) begin
            // drop everything until reset
        end else if (i_end_of_stream) begin
            o_group = '0;
            o_count = '0;
            if (i_count != 3'd0) begin
                if (padded[FullW-1]) begin
                    o_halted        = 1'b1;
                    o_result.emit   = 1'b1;
                    o_result.status = ST_OVERFLOW;
                end else if (i_count != 3'd1) begin
                    o_result.emit  = 1'b1;
                    o_result.data  = padded[31:0];
                    o_result.count = i_count - 3'd1;
                end
            end
        end else if (is_blank) begin
            // skip whitespace
        end else if (i_in_char == 8'(ZeroChar)) begin
            o_result.emit = 1'b1;
            if (i_count != 3'd0) begin
                o_group         = '0;
                o_count         = '0;
                o_halted        = 1'b1;
                o_result.status = ST_Z_IN_GROUP;
            end else begin
                o_result.count = 3'd4;
            end
        end else if (!in_range) begin
            o_group         = '0;
            o_count         = '0;
            o_halted        = 1'b1;
            o_result.emit   = 1'b1;
            o_result.status = ST_BAD_CHAR;
        end else if (i_count == 3'd4) begin
            o_group       = '0;
            o_count       = '0;
            o_result.emit = 1'b1;
            if (acc[FullW-1]) begin
                o_halted        = 1'b1;
                o_result.status = ST_OVERFLOW;
            end else begin
                o_result.data  = acc[31:0];
                o_result.count = 3'd4;
            end
        end else begin
            o_group = acc[GroupW-1:0];
            o_count = i_count + 3'd1;
        end
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    import a85_pkg::*;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_Z     = 8'(ZeroChar);
    localparam int unsigned PadDigit   = 84;
    localparam logic [32:0] MaxGroup   = 33'h0_FFFF_FFFF;
    // Highest group lead that can never overflow, padded or not
    localparam logic [7:0] SafeLead    = 8'd114;
    localparam int RandomItems = 120;
    localparam int CalmTail    = 15;

    typedef struct {
        logic [7:0] ch;
        logic       eos;
        int         gap;
        bit         hold;
        bit         calm;
    } t_char_item;

    typedef struct {
        logic [7:0] data;
        t_status    st;
        logic       last;
    } t_exp_byte;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_char;
    logic       i_end_of_stream;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic [1:0] o_status;
    logic       o_run_last;

    ascii85_stream_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_char       (i_in_char),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_status        (o_status),
        .o_run_last      (o_run_last)
    );

    t_char_item  char_items[$];
    t_exp_byte   decoded_bytes[$];
    int          mismatches = 0;

    // decoder shadow state
    logic [32:0] acc_value;
    int          acc_digits;
    bit          halted;

    // generator state
    bit          gen_bursty;
    bit          gen_hold;
    bit          gen_calm;
    int          gen_digits;

    // driver and monitor state
    t_char_item  cur_item;
    logic        nxt_valid;
    int          idle_cnt = 0;
    bit          calm_phase = 0;
    int          stall_left = 0;
    bit          out_bursty = 1;
    logic        nxt_stall;
    t_exp_byte   want;

    task automatic push_bytes(input logic [31:0] word, input int count);
        t_exp_byte eb;
        for (int k = 0; k < count; k++) begin
            eb.data = word[31 - 8 * k -: 8];
            eb.st   = ST_OK;
            eb.last = (k == count - 1);
            decoded_bytes.insert(decoded_bytes.size(), eb);
        end
    endtask

    task automatic raise_fault(input t_status st);
        t_exp_byte eb;
        acc_value  = '0;
        acc_digits = 0;
        halted     = 1'b1;
        eb.data    = 8'd0;
        eb.st      = st;
        eb.last    = 1'b1;
        decoded_bytes.insert(decoded_bytes.size(), eb);
    endtask

    task automatic decode_char(input logic [7:0] ch, input logic eos);
        logic [32:0] v;
        int          n;
        if (halted) begin
            // drop everything until reset
        end else if (eos) begin
            n = acc_digits;
            v = acc_value;
            acc_value  = '0;
            acc_digits = 0;
            if (n != 0) begin
                for (int i = n; i < 5; i++) v = v * Base + PadDigit;
                if (v > MaxGroup) raise_fault(ST_OVERFLOW);
                else push_bytes(v[31:0], n - 1);
            end
        end else if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
            // skip whitespace
        end else if (ch == CH_Z) begin
            if (acc_digits != 0) raise_fault(ST_Z_IN_GROUP);
            else push_bytes(32'd0, 4);
        end else if (ch < DigitLow || ch > DigitHigh) begin
            raise_fault(ST_BAD_CHAR);
        end else begin
            acc_value = acc_value * Base + (ch - DigitLow);
            acc_digits++;
            if (acc_digits == 5) begin
                v = acc_value;
                acc_value  = '0;
                acc_digits = 0;
                if (v > MaxGroup) raise_fault(ST_OVERFLOW);
                else push_bytes(v[31:0], 4);
            end
        end
    endtask

    task automatic queue_char(input logic [7:0] ch, input logic eos);
        t_char_item it;
        it.ch   = ch;
        it.eos  = eos;
        it.hold = gen_hold;
        it.calm = gen_calm;
        if (gen_calm || !gen_bursty || $urandom_range(0, 3) != 0) it.gap = 0;
        else it.gap = $urandom_range(1, 9);
        gen_hold = 0;
        char_items.insert(char_items.size(), it);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_char(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
    endfunction

    function automatic logic [7:0] pick_bad_char();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 8));
            1: return 8'($urandom_range(14, 31));
            2: return 8'($urandom_range(118, 121));
            default: return 8'($urandom_range(123, 255));
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_char       = 8'd0;
        i_end_of_stream = 1'b0;
        i_out_stall     = 1'b0;
        acc_value       = '0;
        acc_digits      = 0;
        halted          = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    // stimulus
    initial begin
        int counted;
        int r;
        logic [7:0] ch;
        gen_bursty = 1;
        gen_hold   = 0;
        gen_calm   = 0;
        gen_digits = 0;
        counted    = 0;

        // largest legal group, then a zero group
        queue_text("s8W-!");
        queue_char(CH_Z, 1'b0);
        // whitespace from tab to carriage return inside a group, '>' as a digit
        queue_char("!", 1'b0);
        queue_char(CH_TAB, 1'b0);
        queue_char(">", 1'b0);
        queue_char(CH_LF, 1'b0);
        queue_char("!", 1'b0);
        queue_char(CH_VT, 1'b0);
        queue_char("u", 1'b0);
        queue_char(CH_FF, 1'b0);
        queue_char("!", 1'b0);
        queue_char(CH_CR, 1'b0);
        // end of stream with no partial group
        queue_char(8'd0, 1'b1);
        // single trailing digit gives no byte
        queue_char("!", 1'b0);
        queue_char(8'hFF, 1'b1);
        queue_char("9", 1'b0);
        queue_char(CH_SPACE, 1'b0);
        queue_char("j", 1'b0);
        queue_char(8'h80, 1'b1);
        queue_text("r>uu");
        queue_char(8'h7F, 1'b1);

        gen_hold = 1;
        while (counted < RandomItems) begin
            if ($urandom_range(0, 24) == 0) gen_bursty = !gen_bursty;
            if (counted == RandomItems / 2) gen_hold = 1;
            gen_calm = (counted >= RandomItems - CalmTail);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                ch = (gen_digits == 0) ? 8'($urandom_range(DigitLow, SafeLead))
                                       : 8'($urandom_range(DigitLow, DigitHigh));
                queue_char(ch, 1'b0);
                gen_digits = (gen_digits + 1) % 5;
                counted++;
            end else if (r < 78) begin
                // zero group at a boundary, else cut the group short
                if (gen_digits == 0) queue_char(CH_Z, 1'b0);
                else queue_char(8'($urandom_range(0, 255)), 1'b1);
                gen_digits = 0;
                counted++;
            end else if (r < 90) begin
                queue_char(pick_blank(), 1'b0);
            end else begin
                queue_char(8'($urandom_range(0, 255)), 1'b1);
                gen_digits = 0;
                counted++;
            end
        end

        // flush, then one fault, which halts the decoder for good
        gen_calm = 1;
        queue_char(8'($urandom_range(0, 255)), 1'b1);
        case ($urandom_range(0, 3))
            0: queue_text("!z");
            1: queue_char(pick_bad_char(), 1'b0);
            2: queue_text("s8W-\"");
            default: begin
                queue_char(8'($urandom_range(115, 117)), 1'b0);
                queue_char(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        repeat (10) queue_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        @(posedge i_clk);
        while (char_items.size() > 0 || i_in_valid || decoded_bytes.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            nxt_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                decode_char(i_in_char, i_end_of_stream);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && char_items.size() > 0) begin
                if (idle_cnt < char_items[0].gap ||
                    (char_items[0].hold && decoded_bytes.size() > 0)) begin
                    idle_cnt++;
                end else begin
                    cur_item = char_items.pop_front();
                    i_in_char       <= cur_item.ch;
                    i_end_of_stream <= cur_item.eos;
                    calm_phase      <= cur_item.calm;
                    nxt_valid = 1'b1;
                    idle_cnt  = 0;
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (decoded_bytes.size() == 0) begin
                    $display("%0t: unexpected byte: expected none, actual %h status %0d last %b",
                             $time, o_out_byte, o_status, o_run_last);
                    mismatches++;
                end else begin
                    want = decoded_bytes.pop_front();
                    if (o_out_byte !== want.data) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want.data, o_out_byte);
                        mismatches++;
                    end
                    if (o_status !== want.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, o_status);
                        mismatches++;
                    end
                    if (o_run_last !== want.last) begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, want.last, o_run_last);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                nxt_stall = 1'b1;
            end else if (!calm_phase && out_bursty && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 8);
                nxt_stall  = 1'b1;
            end else begin
                nxt_stall = 1'b0;
            end
            if ($urandom_range(0, 59) == 0) out_bursty = !out_bursty;
            i_out_stall <= nxt_stall;
        end
    end

endmodule
